// ----- sv/sort_doubles_exchange_unit_assert.svh -----
// Assertion macros shared by the sort unit.
`ifndef SORT_DOUBLES_EXCHANGE_UNIT_ASSERT_SVH
`define SORT_DOUBLES_EXCHANGE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDXU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sort unit assertion failed");

// Next-cycle implication, checked outside reset.
`define SDXU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sort unit assertion failed");

`endif

// ----- sv/sdxu_pkg.sv -----
package sdxu_pkg;

  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } sdxu_in_t;

  typedef struct packed {
    logic [63:0] sorted_value;
    logic        last_out;
    logic        overflow;
  } sdxu_out_t;

  // IEEE greater-than on double bit patterns. Any NaN gives false, and
  // zeros of either sign compare equal.
  function automatic logic sdxu_gt(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    logic gt;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    if (a_nan || b_nan) begin
      gt = 1'b0;
    end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
      gt = 1'b0;
    end else if (a[63] != b[63]) begin
      gt = b[63];
    end else if (a[63] == 1'b0) begin
      gt = a[62:0] > b[62:0];
    end else begin
      gt = a[62:0] < b[62:0];
    end
    return gt;
  endfunction

endpackage

// ----- sv/sdxu_ram.sv -----
module sdxu_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/sort_doubles_exchange_unit.sv -----
// Channel | Handshake              | Payload
// input   | in_valid_i / in_ready_o  | in_data_i  (value, last)
// output  | out_valid_o / out_ready_i| out_data_o (sorted_value, last_out, overflow)
//
// A run of n items is collected at one item per cycle into a single-port-write RAM.
// Each row but the last reads its entry (ST_RD_I, ST_CAP_I), scans the later
// entries at one RAM read per cycle (ST_SCAN) and writes back (ST_WB); each item
// is then read, captured and held for output, the pace set by the one RAM read port.
// Reset is asynchronous and active low; the store needs no clearing pass.
// Input is refused while a run is sorted or emitted; a stalled output holds.
module sort_doubles_exchange_unit #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sdxu_pkg::sdxu_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sdxu_pkg::sdxu_out_t out_data_o
);
  import sdxu_pkg::*;

  `include "sort_doubles_exchange_unit_assert.svh"

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1) + 1;

  typedef enum logic [2:0] {
    ST_COLLECT, ST_RD_I, ST_CAP_I, ST_SCAN, ST_WB, ST_E_RD, ST_E_CAP, ST_E_OUT
  } state_e;

  state_e         state_q;
  logic [CW-1:0]  cnt_q;
  logic           ovf_q;
  logic [AW-1:0]  i_q;
  logic [CW-1:0]  j_q;
  logic [AW-1:0]  pj_q;
  logic           pend_q;
  logic [63:0]    cur_q;
  logic [AW-1:0]  k_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [63:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [63:0]    ram_rdata;
  logic           swap;
  logic           full;
  logic [CW-1:0]  n_new;

  assign full  = cnt_q >= CW'(MAX_ITEMS);
  assign n_new = full ? cnt_q : cnt_q + CW'(1);
  assign swap  = pend_q && sdxu_gt(cur_q, ram_rdata);
  assign in_ready_o = (state_q == ST_COLLECT);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = cur_q;
    ram_raddr = i_q;
    unique case (state_q)
      ST_COLLECT: begin
        ram_we    = in_valid_i && !full;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = in_data_i.value;
      end
      ST_SCAN: begin
        ram_we    = swap;
        ram_waddr = pj_q;
        ram_raddr = j_q[AW-1:0];
      end
      ST_WB:   ram_we = 1'b1;
      ST_E_RD: ram_raddr = k_q;
      default: ;
    endcase
  end

  sdxu_ram #(.Width(64), .Depth(MAX_ITEMS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      pj_q        <= '0;
      pend_q      <= 1'b0;
      cur_q       <= '0;
      k_q         <= '0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
    end else begin
      unique case (state_q)
        ST_COLLECT: begin
          if (in_valid_i) begin
            cnt_q <= n_new;
            if (full) ovf_q <= 1'b1;
            if (in_data_i.last) begin
              i_q <= '0;
              k_q <= '0;
              state_q <= (n_new >= CW'(2)) ? ST_RD_I : ST_E_RD;
            end
          end
        end
        ST_RD_I: state_q <= ST_CAP_I;
        ST_CAP_I: begin
          cur_q   <= ram_rdata;
          j_q     <= CW'(i_q) + CW'(1);
          pend_q  <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          // The held entry trades places with any smaller later entry.
          if (swap) cur_q <= ram_rdata;
          if (j_q < cnt_q) begin
            pend_q <= 1'b1;
            pj_q   <= j_q[AW-1:0];
            j_q    <= j_q + CW'(1);
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) state_q <= ST_WB;
          end
        end
        ST_WB: begin
          if (CW'(i_q) + CW'(2) < cnt_q) begin
            i_q     <= i_q + AW'(1);
            state_q <= ST_RD_I;
          end else begin
            k_q     <= '0;
            state_q <= ST_E_RD;
          end
        end
        ST_E_RD: state_q <= ST_E_CAP;
        ST_E_CAP: begin
          out_data_o.sorted_value <= ram_rdata;
          out_data_o.last_out     <= (CW'(k_q) + CW'(1) == cnt_q);
          out_data_o.overflow     <= ovf_q;
          out_valid_o             <= 1'b1;
          state_q                 <= ST_E_OUT;
        end
        ST_E_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (out_data_o.last_out) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_COLLECT;
            end else begin
              k_q     <= k_q + AW'(1);
              state_q <= ST_E_RD;
            end
          end
        end
        default: state_q <= ST_COLLECT;
      endcase
    end
  end

  `SDXU_ASSERT_NOW(a_no_overlap, in_ready_o, !out_valid_o)
  `SDXU_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_ITEMS))
  `SDXU_ASSERT_NOW(a_scan_row, state_q == ST_SCAN, CW'(i_q) + CW'(1) < cnt_q)
  `SDXU_ASSERT_NEXT(a_run_done, out_valid_o && out_ready_i && out_data_o.last_out,
                    in_ready_o && cnt_q == '0)

endmodule
